// ===== hdl/sts_pkg.sv =====
//------------------------------------------------------------------------------
// Sphere triangle subdivision package
// Shared constants and types for the midpoint projection pipeline.
//------------------------------------------------------------------------------
package sts_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int RADIUS_W = 31;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
	localparam int NORM_W = 30;
	localparam int SQRT_W = 31;
	localparam int QUOT_W = 62;
	localparam int CHILD_W = 2;
	localparam logic [CHILD_W-1:0] LAST_CHILD_IDX = 2'd3;
endpackage

// ===== hdl/sts_norm.sv =====
//------------------------------------------------------------------------------
// Midpoint normalization front end
// Forms the corner sum, its magnitude and the shift that brings it below 2^30.
// Also squares the shifted magnitudes into the length-squared sum.
//------------------------------------------------------------------------------
module sts_norm #(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [CW-1:0] p_x, p_y, p_z,
	input  logic signed [CW-1:0] q_x, q_y, q_z,
	output logic [2:0]           neg_o,
	output logic [29:0]          t_x_o, t_y_o, t_z_o,
	output logic [61:0]          sum_o
);
	import sts_pkg::*;
	localparam int SW = CW + 1;
	logic signed [SW-1:0] s_x, s_y, s_z;
	logic [SW-1:0] u_x, u_y, u_z, m_c;
	logic [SW-1:0] ux_s1, uy_s1, uz_s1;
	logic [2:0] neg_s1;
	logic [29:0] tx_c, ty_c, tz_c;
	logic [5:0] sh_c;
	logic [29:0] tx_s2, ty_s2, tz_s2;
	logic [2:0] neg_s2;

	always_comb begin
		s_x = SW'(p_x) + SW'(q_x);
		s_y = SW'(p_y) + SW'(q_y);
		s_z = SW'(p_z) + SW'(q_z);
		u_x = s_x[SW-1] ? SW'(-s_x) : SW'(s_x);
		u_y = s_y[SW-1] ? SW'(-s_y) : SW'(s_y);
		u_z = s_z[SW-1] ? SW'(-s_z) : SW'(s_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= u_x;
			uy_s1 <= u_y;
			uz_s1 <= u_z;
			neg_s1 <= {s_z[SW-1], s_y[SW-1], s_x[SW-1]};
		end
	end

	always_comb begin
		m_c = ux_s1 | uy_s1 | uz_s1;
		sh_c = '0;
		for (int i = 0; i < SW; i++) begin
			if (m_c[i] && i >= NORM_W) sh_c = 6'(i - NORM_W + 1);
		end
		tx_c = 30'(ux_s1 >> sh_c);
		ty_c = 30'(uy_s1 >> sh_c);
		tz_c = 30'(uz_s1 >> sh_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2 <= tx_c;
			ty_s2 <= ty_c;
			tz_s2 <= tz_c;
			neg_s2 <= neg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_x_o <= tx_s2;
			t_y_o <= ty_s2;
			t_z_o <= tz_s2;
			neg_o <= neg_s2;
			sum_o <= 62'(tx_s2 * tx_s2) + 62'(ty_s2 * ty_s2) + 62'(tz_s2 * tz_s2);
		end
	end
	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

// ===== hdl/sts_sqrt.sv =====
//------------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root over a 62-bit value, one result bit per stage.
//------------------------------------------------------------------------------
module sts_sqrt #(
	parameter int NB = 31,
	parameter int DW = 3 * 30 + 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [61:0]   v_i,
	input  logic [DW-1:0] d_i,
	output logic [NB-1:0] r_o,
	output logic [DW-1:0] d_o
);
	logic [63:0] rem_q [NB+1];
	logic [NB-1:0] root_q [NB+1];
	logic [DW-1:0] dat_q [NB+1];

	always_comb begin
		rem_q[0] = {2'b00, v_i};
		root_q[0] = '0;
		dat_q[0] = d_i;
	end

	for (genvar g = 0; g < NB; g++) begin : g_st
		localparam int B = NB - 1 - g;
		logic [63:0] trial;
		logic [NB-1:0] rt;
		logic [63:0] rm;
		always_comb begin
			trial = 64'(({33'd0, root_q[g]} << (B + 1)) | (64'd1 << (2 * B)));
			if (rem_q[g] >= trial) begin
				rm = rem_q[g] - trial;
				rt = root_q[g] | (NB'(1) << B);
			end else begin
				rm = rem_q[g];
				rt = root_q[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1] <= rm;
				root_q[g+1] <= rt;
				dat_q[g+1] <= dat_q[g];
			end
		end
	end

	assign r_o = root_q[NB];
	assign d_o = dat_q[NB];
endmodule

// ===== hdl/sts_div.sv =====
//------------------------------------------------------------------------------
// Pipelined rounded divider
// Computes min((t*radius + n/2)/n, max) with one quotient bit per stage.
//------------------------------------------------------------------------------
module sts_div #(
	parameter int CW = 32,
	parameter int DW = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [29:0]   t_i,
	input  logic [30:0]   rad_i,
	input  logic [30:0]   n_i,
	input  logic [DW-1:0] d_i,
	output logic [CW-1:0] q_o,
	output logic [DW-1:0] d_o
);
	localparam int NW = 62;
	logic [NW-1:0] num_s1;
	logic [30:0] n_s1;
	logic [DW-1:0] d_s1;
	logic [NW-1:0] num_q [NW+1];
	logic [31:0] rem_q [NW+1];
	logic [30:0] den_q [NW+1];
	logic [DW-1:0] dat_q [NW+1];
	logic [NW:0] full;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= NW'(t_i * rad_i) + NW'(n_i >> 1);
			n_s1 <= n_i;
			d_s1 <= d_i;
		end
	end

	always_comb begin
		num_q[0] = num_s1;
		rem_q[0] = '0;
		den_q[0] = n_s1;
		dat_q[0] = d_s1;
	end

	for (genvar g = 0; g < NW; g++) begin : g_st
		logic [32:0] sh;
		logic [31:0] rm;
		logic [NW-1:0] nm;
		always_comb begin
			sh = {rem_q[g], num_q[g][NW-1]};
			nm = {num_q[g][NW-2:0], 1'b0};
			if (sh >= {2'b00, den_q[g]}) begin
				rm = 32'(sh - {2'b00, den_q[g]});
				nm[0] = 1'b1;
			end else begin
				rm = sh[31:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1] <= rm;
				num_q[g+1] <= nm;
				den_q[g+1] <= den_q[g];
				dat_q[g+1] <= dat_q[g];
			end
		end
	end

	always_comb begin
		full = {1'b0, num_q[NW]};
		if (full > (NW+1)'((64'd1 << (CW - 1)) - 1)) q_o = CW'((64'd1 << (CW - 1)) - 1);
		else q_o = CW'(num_q[NW]);
	end
	assign d_o = dat_q[NW];
endmodule

// ===== hdl/sts_proj.sv =====
//------------------------------------------------------------------------------
// Midpoint projector
// Projects the midpoint of two corners onto the sphere of the given radius.
//------------------------------------------------------------------------------
module sts_proj #(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [30:0]          radius,
	input  logic signed [CW-1:0] p_x, p_y, p_z,
	input  logic signed [CW-1:0] q_x, q_y, q_z,
	output logic [CW-1:0]        w_x, w_y, w_z,
	output logic                 degen
);
	import sts_pkg::*;
	logic [2:0] neg;
	logic [29:0] tx, ty, tz, sx, sy, sz;
	logic [61:0] sum;
	logic [30:0] n;
	logic [92:0] sd;
	logic [CW-1:0] mx, my, mz;
	logic [3:0] dx, dy, dz;

	sts_norm #(.CW(CW)) u_norm (
		.clk, .arst_n, .en, .p_x, .p_y, .p_z, .q_x, .q_y, .q_z,
		.neg_o(neg), .t_x_o(tx), .t_y_o(ty), .t_z_o(tz), .sum_o(sum)
	);
	sts_sqrt #(.NB(SQRT_W), .DW(93)) u_sqrt (
		.clk, .en, .v_i(sum), .d_i({neg, tx, ty, tz}), .r_o(n), .d_o(sd)
	);
	assign {sx, sy, sz} = sd[89:0];

	sts_div #(.CW(CW), .DW(4)) u_dx (.clk, .en, .t_i(sx), .rad_i(radius), .n_i(n),
		.d_i({n == 0, sd[90], 2'b00}), .q_o(mx), .d_o(dx));
	sts_div #(.CW(CW), .DW(4)) u_dy (.clk, .en, .t_i(sy), .rad_i(radius), .n_i(n),
		.d_i({n == 0, sd[91], 2'b00}), .q_o(my), .d_o(dy));
	sts_div #(.CW(CW), .DW(4)) u_dz (.clk, .en, .t_i(sz), .rad_i(radius), .n_i(n),
		.d_i({n == 0, sd[92], 2'b00}), .q_o(mz), .d_o(dz));

	always_comb begin
		degen = dx[3];
		w_x = dx[3] ? '0 : (dx[2] ? CW'(-mx) : mx);
		w_y = dx[3] ? '0 : (dy[2] ? CW'(-my) : my);
		w_z = dx[3] ? '0 : (dz[2] ? CW'(-mz) : mz);
	end
	logic unused_d;
	assign unused_d = ^{dx[1:0], dy[3], dy[1:0], dz[3], dz[1:0]};
endmodule

// ===== hdl/sphere_triangle_subdivide_core.sv =====
//------------------------------------------------------------------------------
// Sphere triangle subdivision core
// Splits a triangle into four children with midpoints projected to the sphere.
//------------------------------------------------------------------------------
// Once a triangle has passed through the pipeline, its children come out at one child per cycle.
// A new triangle can enter before earlier ones leave; busy rises once start is accepted and blocks further starts.
// The pipeline length is set by the normalization stages, the square root and the pipelined dividers.
// The pipeline advances every cycle; the receiver cannot stall.
// Reset clears valid bits and loads radius with 1.0.
module sphere_triangle_subdivide_core #(
	parameter int COORD_WIDTH = sts_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [sts_pkg::RADIUS_W-1:0]  cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
	output logic                          done,
	output logic [COORD_WIDTH-1:0]        p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
	output logic [sts_pkg::CHILD_W-1:0]   child_index,
	output logic                          last_child,
	output logic                          degenerate
);
	import sts_pkg::*;
	localparam int LAT = 3 + SQRT_W + 1 + QUOT_W;
	localparam int CW = COORD_WIDTH;
	logic [RADIUS_W-1:0] radius_q;
	logic [1:0] slot_q;
	logic acc;
	logic [LAT-1:0] vld_q;
	logic [CW-1:0] v_q [LAT][9];
	logic [CW-1:0] w0 [3], w1 [3], w2 [3];
	logic dg0, dg1, dg2;
	logic [CW-1:0] o0 [3], o1 [3], o2 [3], o3 [3], o4 [3], o5 [3];
	logic [CW-1:0] h0 [3], h1 [3], h2 [3];
	logic deg_q;
	logic [1:0] cnt_q;
	logic out_q;

	assign busy = slot_q != 2'd0;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			slot_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_we) radius_q <= cfg_wdata;
			if (acc || busy) slot_q <= slot_q + 2'd1;
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		v_q[0] <= '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
		for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
	end

	sts_proj #(.CW(CW)) u_p0 (.clk, .arst_n, .en(1'b1), .radius(radius_q),
		.p_x(b_x), .p_y(b_y), .p_z(b_z), .q_x(c_x), .q_y(c_y), .q_z(c_z),
		.w_x(w0[0]), .w_y(w0[1]), .w_z(w0[2]), .degen(dg0));
	sts_proj #(.CW(CW)) u_p1 (.clk, .arst_n, .en(1'b1), .radius(radius_q),
		.p_x(c_x), .p_y(c_y), .p_z(c_z), .q_x(a_x), .q_y(a_y), .q_z(a_z),
		.w_x(w1[0]), .w_y(w1[1]), .w_z(w1[2]), .degen(dg1));
	sts_proj #(.CW(CW)) u_p2 (.clk, .arst_n, .en(1'b1), .radius(radius_q),
		.p_x(a_x), .p_y(a_y), .p_z(a_z), .q_x(b_x), .q_y(b_y), .q_z(b_z),
		.w_x(w2[0]), .w_y(w2[1]), .w_z(w2[2]), .degen(dg2));

	// The finished triangle is held for its four child words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_q <= 1'b0;
		end else if (vld_q[LAT-1]) begin
			cnt_q <= '0;
			out_q <= 1'b1;
		end else if (out_q) begin
			cnt_q <= cnt_q + 2'd1;
			out_q <= cnt_q != LAST_CHILD_IDX;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[LAT-1]) begin
			for (int k = 0; k < 3; k++) begin
				h0[k] <= v_q[LAT-1][k];
				h1[k] <= v_q[LAT-1][3+k];
				h2[k] <= v_q[LAT-1][6+k];
				o0[k] <= w0[k];
				o1[k] <= w1[k];
				o2[k] <= w2[k];
			end
			deg_q <= dg0 | dg1 | dg2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			o3[k] = '0; o4[k] = '0; o5[k] = '0;
			case (cnt_q)
				2'd0: begin o3[k] = h0[k]; o4[k] = o2[k]; o5[k] = o1[k]; end
				2'd1: begin o3[k] = o2[k]; o4[k] = h1[k]; o5[k] = o0[k]; end
				2'd2: begin o3[k] = o0[k]; o4[k] = h2[k]; o5[k] = o1[k]; end
				default: begin o3[k] = o0[k]; o4[k] = o1[k]; o5[k] = o2[k]; end
			endcase
		end
	end

	assign done = out_q;
	assign {p_x, p_y, p_z} = {o3[0], o3[1], o3[2]};
	assign {q_x, q_y, q_z} = {o4[0], o4[1], o4[2]};
	assign {r_x, r_y, r_z} = {o5[0], o5[1], o5[2]};
	assign child_index = cnt_q;
	assign last_child = cnt_q == LAST_CHILD_IDX;
	assign degenerate = deg_q;

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) acc |=> busy)
		else $error("busy not raised after start");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> !vld_q[1] && !vld_q[2] && !vld_q[3])
		else $error("triangles closer than four cycles");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_child |=> !done || child_index == 2'd0)
		else $error("child order broken");
endmodule

// ===== test/sts_checker.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Sphere triangle subdivision checker
// Watches accepted triangles and radius writes, predicts the four child words
// of each triangle, and compares every strobed child word with the oldest one.
//------------------------------------------------------------------------------
module sts_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         cfg_we,
	input  logic [sts_pkg::RADIUS_W-1:0] cfg_wdata,
	input  logic [31:0]                  a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
	input  logic                         done,
	input  logic [31:0]                  p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
	input  logic [sts_pkg::CHILD_W-1:0]  child_index,
	input  logic                         last_child,
	input  logic                         degenerate,
	output int                           fail_count,
	output int                           pending
);
	typedef struct packed {
		logic [2:0][31:0] p, q, r;
		logic [1:0] idx;
		logic last, degen;
	} child_t;

	child_t child_q[$];
	logic [30:0] radius_reg;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [2:0][31:0] project_midpoint(logic [2:0][31:0] pa,
			logic [2:0][31:0] pb, output logic degen);
		logic signed [63:0] s [3];
		logic [63:0] u [3], t [3], m, sum, n, mag;
		logic [2:0][31:0] w;
		int sh;
		m = 0;
		sum = 0;
		sh = 0;
		for (int k = 0; k < 3; k++) begin
			s[k] = 64'(signed'(pa[k])) + 64'(signed'(pb[k]));
			u[k] = s[k] < 0 ? -s[k] : s[k];
			if (u[k] > m) m = u[k];
		end
		while ((m >> sh) >= 64'd1 << 30) sh++;
		for (int k = 0; k < 3; k++) begin
			t[k] = u[k] >> sh;
			sum += t[k] * t[k];
		end
		n = int_sqrt(sum);
		degen = (n == 0);
		w = '0;
		if (!degen) begin
			for (int k = 0; k < 3; k++) begin
				mag = (t[k] * radius_reg + (n >> 1)) / n;
				if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
				w[k] = s[k] < 0 ? 32'(-mag) : 32'(mag);
			end
		end
		return w;
	endfunction

	task automatic push_children(logic [2:0][31:0] v0, v1, v2);
		logic [2:0][31:0] w0, w1, w2;
		logic d0, d1, d2, dg;
		child_t ch;
		w0 = project_midpoint(v1, v2, d0);
		w1 = project_midpoint(v2, v0, d1);
		w2 = project_midpoint(v0, v1, d2);
		dg = d0 | d1 | d2;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0: begin ch.p = v0; ch.q = w2; ch.r = w1; end
				1: begin ch.p = w2; ch.q = v1; ch.r = w0; end
				2: begin ch.p = w0; ch.q = v2; ch.r = w1; end
				default: begin ch.p = w0; ch.q = w1; ch.r = w2; end
			endcase
			ch.idx = 2'(i);
			ch.last = (2'(i) == sts_pkg::LAST_CHILD_IDX);
			ch.degen = dg;
			child_q.push_back(ch);
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		child_t want, got;
		if (!arst_n) begin
			radius_reg <= sts_pkg::RADIUS_RESET;
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				got.p = {p_z, p_y, p_x};
				got.q = {q_z, q_y, q_x};
				got.r = {r_z, r_y, r_x};
				got.idx = child_index;
				got.last = last_child;
				got.degen = degenerate;
				if (child_q.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					want = child_q.pop_front();
					for (int k = 0; k < 3; k++) begin
						if (got.p[k] !== want.p[k]) report_mismatch("p", got.p[k], want.p[k]);
						if (got.q[k] !== want.q[k]) report_mismatch("q", got.q[k], want.q[k]);
						if (got.r[k] !== want.r[k]) report_mismatch("r", got.r[k], want.r[k]);
					end
					if (got.idx !== want.idx) report_mismatch("child_index", got.idx, want.idx);
					if (got.last !== want.last) report_mismatch("last_child", got.last, want.last);
					if (got.degen !== want.degen)
						report_mismatch("degenerate", got.degen, want.degen);
				end
			end
			if (start && !busy)
				push_children({a_z, a_y, a_x}, {b_z, b_y, b_x}, {c_z, c_y, c_x});
			if (cfg_we) radius_reg <= cfg_wdata;
			pending = child_q.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Sphere triangle subdivision testbench
// Drives directed and random triangles under several radius settings with
// random start gaps; the checker predicts and compares every child word.
//------------------------------------------------------------------------------
module tb_top;
	logic clk, arst_n, start, busy, cfg_we, done, last_child, degenerate;
	logic [30:0] cfg_wdata;
	logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic [31:0] p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z;
	logic [1:0] child_index;
	int fail_count, pending;

	sphere_triangle_subdivide_core uut (.*);
	sts_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 1) ? 0 : -1);
			3: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
			default: return $urandom();
		endcase
	endfunction

	// The busy window after each accepted word leaves room for the idle edge below.
	task automatic send_triangle(logic [8:0][31:0] v, bit gaps);
		@(posedge clk);
		if (gaps) begin
			while ($urandom_range(0, 99) < 30) @(posedge clk);
		end
		{c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x} <= v;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 0;
	endtask

	task automatic write_radius(logic [30:0] val);
		while (pending != 0) @(posedge clk);
		repeat (110) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int count, bit gaps);
		logic [8:0][31:0] v;
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 9; k++) v[k] = rand_coord();
			if ($urandom_range(0, 9) == 0) begin
				v[3] = -v[6]; v[4] = -v[7]; v[5] = -v[8];
			end
			send_triangle(v, gaps);
		end
	endtask

	initial begin
		logic [30:0] radii [5];
		radii = '{31'd1, 31'h7FFF_FFFF, 31'd65536 * 5, 31'd0, 31'd65536};
		arst_n = 0;
		start = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_triangle({9{32'h0}}, 0);
		send_triangle({9{32'h8000_0000}}, 0);
		send_triangle({9{32'h7FFF_FFFF}}, 0);
		send_triangle({32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0,
			32'h10000, 32'h0, 32'h0}, 0);
		send_triangle({32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0001_0000, 32'h0, 32'h0}, 0);
		send_triangle({32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3}, 0);
		random_phase(40, 0);
		foreach (radii[i]) begin
			write_radius(radii[i]);
			send_triangle({32'h0, 32'h0, 32'h7FFF_0000, 32'h0, 32'h7FFF_0000, 32'h0,
				32'h7FFF_0000, 32'h0, 32'h0}, 1);
			random_phase(44, 1);
		end
		while (pending != 0) @(posedge clk);
		repeat (110) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ===== sphere_triangle_subdivide_core.f =====
hdl/sts_pkg.sv
hdl/sts_norm.sv
hdl/sts_sqrt.sv
hdl/sts_div.sv
hdl/sts_proj.sv
hdl/sphere_triangle_subdivide_core.sv
test/sts_checker.sv
test/tb_top.sv
